/* src/rfp_pkg.sv */
// Shared types, codes and constants of the rotating framebuffer packetizer.
`default_nettype none

package rfp_pkg;

  // Default sizes handed to the top level.
  localparam int RFP_MAX_SIDE  = 64;
  localparam int RFP_PAD_BYTES = 64;

  // Side length after reset, before saturation.
  localparam int SIDE_RESET = 16;

  // Width of the signed arithmetic used for rotated coordinates.
  localparam int CW = 10;

  // Width of the length field in the packet headers.
  localparam int LEN_W = 16;

  // Frame stream constants.
  localparam logic [7:0] SOF_BYTE = 8'hAA;
  localparam logic [7:0] EOF_BYTE = 8'hBB;
  localparam logic [7:0] CMD_PIXELS = 8'h00;
  localparam logic [7:0] CMD_PAD  = 8'h21;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Register select bit (paddr[2]).
  localparam logic REG_SIDE = 1'b0;
  localparam logic REG_ROT  = 1'b1;

  typedef enum logic [1:0] {
    OP_RGB888 = 2'd0,
    OP_RGB565 = 2'd1,
    OP_FILL   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_FILL,
    ST_READ
  } st_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        byte_first;
    logic [7:0]        byte_second;
    logic              hi_first;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

endpackage

`default_nettype wire

/* src/rfp_stream_if.sv */
// Valid/ready stream interface with a typed payload.
`default_nettype none

interface rfp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/rfp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rfp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/rotating_framebuffer_packetizer.sv */
// Top level: rotating RGB888 framebuffer with packetized frame readout.
//
// Items arrive on in_i (valid/ready). Pixel writes (RGB888 or RGB565) first
// register the color and the rotated coordinate; in ST_WRITE the address is
// then formed and the pixel word is written if it lies in bounds. A fill
// writes one pixel per cycle and holds in_i.ready low until all side*side
// pixels are written. A read of the next frame byte waits in ST_READ until
// the output register on out_o is free, then loads the byte into it; payload
// bytes come from the registered read data of the pixel under the readout
// pointer. The pixel RAM port takes one pixel word per cycle.
// The output register decouples the sides: a new item is taken while a
// result waits; a further read waits in its own state until out_o drains.
// After reset all MAX_SIDE*MAX_SIDE words of the pixel RAM are cleared, one
// word per cycle, while in_i.ready stays low; APB writes are taken as ever.
// Writing side_length restarts the frame stream at its first byte.
`default_nettype none

module rotating_framebuffer_packetizer
  import rfp_pkg::*;
#(
  parameter int MAX_SIDE  = RFP_MAX_SIDE,
  parameter int PAD_BYTES = RFP_PAD_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  rfp_stream_if.sink       in_i,
  rfp_stream_if.source     out_o
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CRD_W  = $clog2(MAX_SIDE);
  localparam int PIX_N  = MAX_SIDE * MAX_SIDE;
  localparam int PIX_W  = $clog2(PIX_N);
  localparam int PIXC_W = $clog2(PIX_N + 1);
  localparam int POS_W  = $clog2(3 * PIX_N + 5 + PAD_BYTES);

  localparam int RST_EFF = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
  localparam int RST_PXN = RST_EFF * RST_EFF;
  localparam int RST_LEN = 3 * RST_PXN;

  localparam logic [LEN_W-1:0] PAD_LEN = LEN_W'(PAD_BYTES - 5);

  // Configuration registers and values derived from the side length.
  logic [6:0]        side_q;
  rot_e              rot_q;
  logic [SIDE_W-1:0] eff_q;
  logic [PIXC_W-1:0] pxn_q;
  logic [LEN_W-1:0]  len_q;

  logic              cfg_wr;
  logic [7:0]        sat_side;
  logic [SIDE_W-1:0] eff_d;
  logic [PIXC_W-1:0] pxn_d;
  logic [LEN_W-1:0]  len_d;

  // Frame readout pointer.
  logic [POS_W-1:0]  pos_q;
  logic [PIX_W-1:0]  pix_q;
  logic [1:0]        sub_q;

  // Captured pixel write.
  logic [23:0]       col_q;
  logic [CRD_W-1:0]  rx_q, ry_q;
  logic              wr_ok_q;

  st_e               state_q, state_d;
  logic [PIX_W-1:0]  fill_q;
  logic              fill_last;

  out_item_t         out_q;
  logic              out_v_q;
  out_item_t         out_d;
  logic              out_load;

  logic              mem_we;
  logic [PIX_W-1:0]  mem_waddr;
  logic [23:0]       mem_wdata;
  logic [23:0]       mem_rdata;
  logic [PIX_W-1:0]  wr_addr;
  logic [PIXC_W-1:0] wr_prod;

  logic              in_acc;
  op_e               in_op;

  // ---------------------------------------------------------------------
  // APB configuration port.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    sat_side = {1'b0, pwdata[6:0]};
    if (sat_side < 8'd8) begin
      sat_side = 8'd8;
    end else if (sat_side > 8'(MAX_SIDE)) begin
      sat_side = 8'(MAX_SIDE);
    end
    eff_d = SIDE_W'(sat_side);
    pxn_d = PIXC_W'(eff_d) * PIXC_W'(eff_d);
    len_d = LEN_W'(pxn_d) + (LEN_W'(pxn_d) << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 7'(SIDE_RESET);
      rot_q  <= ROT_0;
      eff_q  <= SIDE_W'(RST_EFF);
      pxn_q  <= PIXC_W'(RST_PXN);
      len_q  <= LEN_W'(RST_LEN);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SIDE: begin
          side_q <= pwdata[6:0];
          eff_q  <= eff_d;
          pxn_q  <= pxn_d;
          len_q  <= len_d;
        end
        REG_ROT: begin
          rot_q <= rot_e'(pwdata[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIDE: prdata = 32'(side_q);
      REG_ROT:  prdata = 32'(rot_q);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input capture: color conversion and rotation.
  // ---------------------------------------------------------------------
  assign in_acc = in_i.valid && in_i.ready;
  assign in_op  = op_e'(in_i.payload.operation);

  logic [15:0]          w565;
  logic [23:0]          col_d;
  logic signed [CW-1:0] sx, sy, ss, rxs, rys;
  logic                 ok_d;

  always_comb begin
    w565 = in_i.payload.hi_first ? {in_i.payload.byte_first, in_i.payload.byte_second}
                                 : {in_i.payload.byte_second, in_i.payload.byte_first};
    if (in_op == OP_RGB565) begin
      col_d = {w565[15:11], w565[15:13], w565[10:5], w565[10:9],
               w565[4:0], w565[4:2]};
    end else begin
      col_d = {in_i.payload.red, in_i.payload.green, in_i.payload.blue};
    end
  end

  always_comb begin
    sx = {{(CW-8){in_i.payload.x[7]}}, in_i.payload.x};
    sy = {{(CW-8){in_i.payload.y[7]}}, in_i.payload.y};
    ss = $signed({{(CW-SIDE_W){1'b0}}, eff_q});
    case (rot_q)
      ROT_90: begin
        rxs = ss - sy - 10'sd1;
        rys = sx;
      end
      ROT_180: begin
        rxs = ss - sx - 10'sd1;
        rys = ss - sy - 10'sd1;
      end
      ROT_270: begin
        rxs = sy;
        rys = ss - sx - 10'sd1;
      end
      default: begin
        rxs = sx;
        rys = sy;
      end
    endcase
    ok_d = (rxs >= 10'sd0) && (rxs < ss) && (rys >= 10'sd0) && (rys < ss);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q   <= col_d;
      rx_q    <= rxs[CRD_W-1:0];
      ry_q    <= rys[CRD_W-1:0];
      wr_ok_q <= ok_d;
    end
  end

  // Row-major pixel address; in-bounds coordinates keep it below side*side.
  assign wr_prod = PIXC_W'(ry_q) * PIXC_W'(eff_q) + PIXC_W'(rx_q);
  assign wr_addr = wr_prod[PIX_W-1:0];

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    case (state_q)
      ST_CLEAR: fill_last = (fill_q == PIX_W'(PIX_N - 1));
      default:  fill_last = (fill_q == PIX_W'(pxn_q - PIXC_W'(1)));
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (fill_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_op)
            OP_RGB888: state_d = ST_WRITE;
            OP_RGB565: state_d = ST_WRITE;
            OP_FILL:   state_d = ST_FILL;
            OP_READ:   state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_FILL: begin
        if (fill_last) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (!out_v_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = fill_q;
    mem_wdata  = col_q;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = wr_ok_q;
        mem_waddr = wr_addr;
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_READ: begin
        out_load = !out_v_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR || state_q == ST_FILL) begin
        fill_q <= fill_last ? '0 : fill_q + PIX_W'(1);
      end
    end
  end

  // The read port always looks at the pixel under the readout pointer.
  rfp_ram #(
    .WIDTH (24),
    .DEPTH (PIX_N)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (pix_q),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Frame stream byte selection.
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] len_p, pay_end, pad_off, last_pos;
  logic             in_payload;
  logic [7:0]       store_byte;

  always_comb begin
    len_p      = POS_W'(len_q);
    pay_end    = len_p + POS_W'(4);
    pad_off    = pos_q - (len_p + POS_W'(5));
    last_pos   = len_p + POS_W'(PAD_BYTES + 4);
    in_payload = (pos_q >= POS_W'(4)) && (pos_q < pay_end);
    case (sub_q)
      2'd0:    store_byte = mem_rdata[23:16];
      2'd1:    store_byte = mem_rdata[15:8];
      default: store_byte = mem_rdata[7:0];
    endcase

    out_d.last_byte = (pos_q == last_pos);
    if (pos_q == POS_W'(0)) begin
      out_d.frame_byte = SOF_BYTE;
    end else if (pos_q == POS_W'(1)) begin
      out_d.frame_byte = len_q[7:0];
    end else if (pos_q == POS_W'(2)) begin
      out_d.frame_byte = len_q[15:8];
    end else if (pos_q == POS_W'(3)) begin
      out_d.frame_byte = CMD_PIXELS;
    end else if (in_payload) begin
      out_d.frame_byte = store_byte;
    end else if (pos_q == pay_end) begin
      out_d.frame_byte = EOF_BYTE;
    end else if (pad_off == POS_W'(PAD_BYTES - 1)) begin
      out_d.frame_byte = EOF_BYTE;
    end else if (pad_off == POS_W'(0)) begin
      out_d.frame_byte = SOF_BYTE;
    end else if (pad_off == POS_W'(1)) begin
      out_d.frame_byte = PAD_LEN[7:0];
    end else if (pad_off == POS_W'(2)) begin
      out_d.frame_byte = PAD_LEN[15:8];
    end else if (pad_off == POS_W'(3)) begin
      out_d.frame_byte = CMD_PAD;
    end else begin
      out_d.frame_byte = ZERO_BYTE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      pix_q <= '0;
      sub_q <= '0;
    end else if (cfg_wr && paddr[2] == REG_SIDE) begin
      pos_q <= '0;
      pix_q <= '0;
      sub_q <= '0;
    end else if (out_load) begin
      if (out_d.last_byte) begin
        pos_q <= '0;
        pix_q <= '0;
        sub_q <= '0;
      end else begin
        pos_q <= pos_q + POS_W'(1);
        if (in_payload) begin
          if (sub_q == 2'd2) begin
            sub_q <= '0;
            pix_q <= pix_q + PIX_W'(1);
          end else begin
            sub_q <= sub_q + 2'd1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= last_pos)
    else $error("readout pointer ran past the end of the frame");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("byte-in-pixel counter out of range");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_FILL || state_q == ST_WRITE))
    else $error("pixel RAM written outside a write state");

  a_read_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && state_d == ST_IDLE) |=> out_v_q)
    else $error("read finished without a result in the output register");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_acc)
    else $error("item transferred during the clearing pass");

endmodule

`default_nettype wire
